/* rtl/core/assert_macros.svh */
// Assertion macros shared by the tangent basis RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttb assertion failed");

// Next-cycle implication, disabled during reset.
`define TTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttb assertion failed");

`endif

/* rtl/core/ttb_pkg.sv */
// Shared constants for the triangle tangent basis pipeline.
// No dependencies; used by ttb_norm and triangle_tangent_basis_top.
package ttb_pkg;

  // Input formats.
  localparam int CoordBits = 16;
  localparam int TexBits   = 16;
  localparam int ThrBits   = 28;

  // Internal widths.
  localparam int EdgeW    = CoordBits + 1;
  localparam int PW       = 2 * EdgeW;
  localparam int CompW    = PW + 1;
  localparam int NormBits = 30;
  localparam int ShW      = $clog2(CompW);
  localparam int SqW      = 2 * NormBits + 2;
  localparam int LenW     = NormBits + 1;
  localparam int UnitW    = 16;
  localparam int QW       = UnitW - 1;
  localparam int DivW     = LenW + QW;

  // Normalizer latency in enabled cycles, input to registered output.
  localparam int NormLat = 5 + LenW + 1 + QW + 1;

  localparam logic [ThrBits-1:0] ThrReset = 28'd26844;
  localparam logic [UnitW-1:0]   UnitOne  = 16'd16384;

  localparam logic [3*UnitW-1:0] IdTangent  = {16'd0, 16'd0, UnitOne};
  localparam logic [3*UnitW-1:0] IdBinormal = {16'd0, UnitOne, 16'd0};
  localparam logic [3*UnitW-1:0] IdNormal   = {UnitOne, 16'd0, 16'd0};

endpackage

/* rtl/core/ttb_norm.sv */
// Pipelined 3-vector normalizer: pre-shift, sum of squares, bit-serial
// square root and restoring division, one stage per bit. Uses ttb_pkg.
module ttb_norm import ttb_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [2:0][CompW-1:0]       comp_i,
  input  logic                        flip_i,
  output logic [2:0][UnitW-1:0]       unit_o
);

  // Input register.
  logic [2:0][CompW-1:0] c_q;
  logic                  flip_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q    <= comp_i;
      flip_q <= flip_i;
    end
  end

  // Sign and magnitude.
  logic [2:0][CompW-1:0] mag_d, mag_q;
  logic [2:0]            neg_d, neg_b_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = c_q[i][CompW-1] ^ flip_q;
      mag_d[i] = c_q[i][CompW-1] ? (~c_q[i] + 1'b1) : c_q[i];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      neg_b_q <= neg_d;
    end
  end

  // Shift right until the largest magnitude is below 2^NormBits.
  logic [CompW-1:0]         orv;
  logic [ShW-1:0]           sh;
  logic [2:0][NormBits-1:0] ms_d, ms_c_q;
  logic [2:0]               neg_c_q;
  always_comb begin
    orv = mag_q[0] | mag_q[1] | mag_q[2];
    sh  = '0;
    for (int b = NormBits; b < CompW; b++) begin
      if (orv[b]) begin
        sh = ShW'(b - NormBits + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      ms_d[i] = NormBits'(mag_q[i] >> sh);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ms_c_q  <= ms_d;
      neg_c_q <= neg_b_q;
    end
  end

  // Squares.
  logic [2*NormBits-1:0]    sq_q [3];
  logic [2:0][NormBits-1:0] ms_d_q;
  logic [2:0]               neg_dd_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= ms_c_q[i] * ms_c_q[i];
      end
      ms_d_q   <= ms_c_q;
      neg_dd_q <= neg_c_q;
    end
  end

  // Square root stages; index 0 holds the sum of squares.
  logic [SqW-1:0]           sx_q [LenW+1];
  logic [SqW-1:0]           sr_q [LenW+1];
  logic [2:0][NormBits-1:0] sm_q [LenW+1];
  logic [2:0]               sn_q [LenW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q[0] <= SqW'(sq_q[0]) + SqW'(sq_q[1]) + SqW'(sq_q[2]);
      sr_q[0] <= '0;
      sm_q[0] <= ms_d_q;
      sn_q[0] <= neg_dd_q;
    end
  end

  for (genvar k = 0; k < LenW; k++) begin : g_sqrt
    localparam logic [SqW-1:0] StepBit = SqW'(1) << (2 * (LenW - 1 - k));
    logic [SqW:0]   trial;
    logic [SqW-1:0] sx_d, sr_d;
    always_comb begin
      trial = {1'b0, sr_q[k]} + {1'b0, StepBit};
      if ({1'b0, sx_q[k]} >= trial) begin
        sx_d = sx_q[k] - trial[SqW-1:0];
        sr_d = (sr_q[k] >> 1) + StepBit;
      end else begin
        sx_d = sx_q[k];
        sr_d = sr_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sx_q[k+1] <= sx_d;
        sr_q[k+1] <= sr_d;
        sm_q[k+1] <= sm_q[k];
        sn_q[k+1] <= sn_q[k];
      end
    end
  end

  // Division stages; index 0 holds the rounded numerators.
  logic [2:0][DivW-1:0] dr_q [QW+1];
  logic [2:0][QW-1:0]   dq_q [QW+1];
  logic [LenW-1:0]      dl_q [QW+1];
  logic                 dz_q [QW+1];
  logic [2:0]           dn_q [QW+1];
  logic [LenW-1:0]      len;

  assign len = sr_q[LenW][LenW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= (DivW'(sm_q[LenW][i]) << (QW - 1)) + DivW'(len >> 1);
      end
      dq_q[0] <= '0;
      dl_q[0] <= len;
      dz_q[0] <= (len == '0);
      dn_q[0] <= sn_q[LenW];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int Sh = QW - 1 - j;
    logic [DivW-1:0]      den;
    logic [2:0][DivW-1:0] dr_d;
    logic [2:0][QW-1:0]   dq_d;
    always_comb begin
      den  = DivW'(dl_q[j]) << Sh;
      dr_d = dr_q[j];
      dq_d = dq_q[j];
      for (int i = 0; i < 3; i++) begin
        if (dr_q[j][i] >= den) begin
          dr_d[i]     = dr_q[j][i] - den;
          dq_d[i][Sh] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[j+1] <= dr_d;
        dq_q[j+1] <= dq_d;
        dl_q[j+1] <= dl_q[j];
        dz_q[j+1] <= dz_q[j];
        dn_q[j+1] <= dn_q[j];
      end
    end
  end

  // Restore signs; a zero-length vector gives zero.
  logic [2:0][UnitW-1:0] unit_d, unit_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dz_q[QW]) begin
        unit_d[i] = '0;
      end else if (dn_q[QW][i]) begin
        unit_d[i] = -{1'b0, dq_q[QW][i]};
      end else begin
        unit_d[i] = {1'b0, dq_q[QW][i]};
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_q <= unit_d;
    end
  end

  assign unit_o = unit_q;

endmodule

/* rtl/core/triangle_tangent_basis_top.sv */
// Top level of the per-triangle tangent basis pipeline.
// Depends on ttb_pkg, ttb_norm and assert_macros.svh.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   positions and texture coordinates
// out      output     out_valid_o/out_stall_i tangent, binormal, normal, degenerate
// cfg      input      cfg_valid_i/cfg_ready_o det_threshold write data
//
// One triangle enters every cycle unless the output stalls; each result passes
// through the two normalizers' square root and divider stages.
// Reset clears the valid bits and loads det_threshold with its reset value.
// A stall at the output while it holds a valid result freezes the whole pipeline, the input stalls with it.
`include "assert_macros.svh"

module triangle_tangent_basis_top import ttb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [47:0]          first_position_i,
  input  logic [47:0]          second_position_i,
  input  logic [47:0]          third_position_i,
  input  logic [31:0]          first_texcoord_i,
  input  logic [31:0]          second_texcoord_i,
  input  logic [31:0]          third_texcoord_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [47:0]          tangent_out_o,
  output logic [47:0]          binormal_out_o,
  output logic [47:0]          normal_out_o,
  output logic                 degenerate_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ThrBits-1:0]   cfg_data_i
);

  localparam int N1Out = 4 + NormLat;
  localparam int X2    = N1Out + 2;
  localparam int N2Out = X2 + NormLat;
  localparam int Depth = N2Out + 1;

  logic en;
  logic [Depth:1] valid_q;
  logic [ThrBits-1:0] thr_q;

  // Whole pipeline advances unless the output holds a stalled result.
  assign en          = !(valid_q[Depth] && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-1:1], in_valid_i};
    end
  end

  // Stage 1: input register.
  logic [47:0] pos_q [3];
  logic [31:0] tex_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= first_position_i;
      pos_q[1] <= second_position_i;
      pos_q[2] <= third_position_i;
      tex_q[0] <= first_texcoord_i;
      tex_q[1] <= second_texcoord_i;
      tex_q[2] <= third_texcoord_i;
    end
  end

  // Stage 2: position and texture edges.
  logic signed [EdgeW-1:0] e1_q [3];
  logic signed [EdgeW-1:0] e2_q [3];
  logic signed [EdgeW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= EdgeW'($signed(pos_q[1][i*CoordBits +: CoordBits]))
                 - EdgeW'($signed(pos_q[0][i*CoordBits +: CoordBits]));
        e2_q[i] <= EdgeW'($signed(pos_q[2][i*CoordBits +: CoordBits]))
                 - EdgeW'($signed(pos_q[0][i*CoordBits +: CoordBits]));
      end
      du1_q <= EdgeW'($signed(tex_q[1][TexBits-1:0])) - EdgeW'($signed(tex_q[0][TexBits-1:0]));
      dv1_q <= EdgeW'($signed(tex_q[1][31:TexBits])) - EdgeW'($signed(tex_q[0][31:TexBits]));
      du2_q <= EdgeW'($signed(tex_q[2][TexBits-1:0])) - EdgeW'($signed(tex_q[0][TexBits-1:0]));
      dv2_q <= EdgeW'($signed(tex_q[2][31:TexBits])) - EdgeW'($signed(tex_q[0][31:TexBits]));
    end
  end

  // Stage 3: products.
  logic signed [PW-1:0] pt1_q [3];
  logic signed [PW-1:0] pt2_q [3];
  logic signed [PW-1:0] pb1_q [3];
  logic signed [PW-1:0] pb2_q [3];
  logic signed [PW-1:0] pd1_q, pd2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pt1_q[i] <= dv2_q * e1_q[i];
        pt2_q[i] <= dv1_q * e2_q[i];
        pb1_q[i] <= du1_q * e2_q[i];
        pb2_q[i] <= du2_q * e1_q[i];
      end
      pd1_q <= du1_q * dv2_q;
      pd2_q <= du2_q * dv1_q;
    end
  end

  // Stage 4: tangent, binormal and determinant.
  logic signed [CompW-1:0] t_q [3];
  logic signed [CompW-1:0] b_q [3];
  logic signed [CompW-1:0] det_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= CompW'(pt1_q[i]) - CompW'(pt2_q[i]);
        b_q[i] <= CompW'(pb1_q[i]) - CompW'(pb2_q[i]);
      end
      det_q <= CompW'(pd1_q) - CompW'(pd2_q);
    end
  end

  // Degenerate test, carried alongside the data.
  logic signed [CompW-1:0] thr_s;
  logic                    deg_d;
  logic                    deg_q [Depth:5];
  assign thr_s = CompW'($signed({1'b0, thr_q}));
  assign deg_d = (det_q == '0) || ((det_q < thr_s) && (det_q > -thr_s));

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q[5] <= deg_d;
      for (int k = 6; k <= Depth; k++) begin
        deg_q[k] <= deg_q[k-1];
      end
    end
  end

  // First normalizers: tangent and binormal, flipped by the determinant sign.
  logic [2:0][CompW-1:0] t_pk, b_pk;
  logic [2:0][UnitW-1:0] tn, bn;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_pk[i] = t_q[i];
      b_pk[i] = b_q[i];
    end
  end

  ttb_norm u_norm_t (
    .clk_i  (clk_i),
    .en_i   (en),
    .comp_i (t_pk),
    .flip_i (det_q[CompW-1]),
    .unit_o (tn)
  );

  ttb_norm u_norm_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .comp_i (b_pk),
    .flip_i (det_q[CompW-1]),
    .unit_o (bn)
  );

  // Tangent and binormal wait for the normal.
  logic [2*3*UnitW-1:0] tb_q [N2Out:N1Out+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      tb_q[N1Out+1] <= {bn, tn};
      for (int k = N1Out + 2; k <= N2Out; k++) begin
        tb_q[k] <= tb_q[k-1];
      end
    end
  end

  // Cross product: products, then differences.
  logic signed [2*UnitW-1:0] cp_q [6];
  logic [2:0][CompW-1:0]     n_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q[0] <= $signed(tn[1]) * $signed(bn[2]);
      cp_q[1] <= $signed(tn[2]) * $signed(bn[1]);
      cp_q[2] <= $signed(tn[2]) * $signed(bn[0]);
      cp_q[3] <= $signed(tn[0]) * $signed(bn[2]);
      cp_q[4] <= $signed(tn[0]) * $signed(bn[1]);
      cp_q[5] <= $signed(tn[1]) * $signed(bn[0]);
      n_q[0]  <= CompW'(cp_q[0]) - CompW'(cp_q[1]);
      n_q[1]  <= CompW'(cp_q[2]) - CompW'(cp_q[3]);
      n_q[2]  <= CompW'(cp_q[4]) - CompW'(cp_q[5]);
    end
  end

  logic [2:0][UnitW-1:0] nn;
  ttb_norm u_norm_n (
    .clk_i  (clk_i),
    .en_i   (en),
    .comp_i (n_q),
    .flip_i (1'b0),
    .unit_o (nn)
  );

  // Output register.
  logic [47:0] tan_q, bin_q, nrm_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (deg_q[Depth-1]) begin
        tan_q <= IdTangent;
        bin_q <= IdBinormal;
        nrm_q <= IdNormal;
      end else begin
        tan_q <= tb_q[N2Out][3*UnitW-1:0];
        bin_q <= tb_q[N2Out][2*3*UnitW-1:3*UnitW];
        nrm_q <= nn;
      end
    end
  end

  assign out_valid_o    = valid_q[Depth];
  assign tangent_out_o  = tan_q;
  assign binormal_out_o = bin_q;
  assign normal_out_o   = nrm_q;
  assign degenerate_o   = deg_q[Depth];

  `TTB_ASSERT_IMP(a_deg_identity, out_valid_o && degenerate_o, tangent_out_o == IdTangent && normal_out_o == IdNormal)
  `TTB_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `TTB_ASSERT_NEXT(a_freeze, in_stall_o, $stable(valid_q))

endmodule
